/* rtl/core/bol_pkg.sv */
// Shared widths, codes and controller/datapath interface types of the ordered list unit.
package bol_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int FPOS_W   = 5;

    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_REAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DISPLAY   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef enum logic [2:0] {
        P_HOLD,
        P_ZERO,
        P_TOP,
        P_POS,
        P_INC,
        P_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        W_NONE,
        W_FRONT,
        W_REAR,
        W_SHIFT
    } t_wr_op;

    typedef enum logic [1:0] {
        C_HOLD,
        C_INC,
        C_DEC
    } t_cnt_op;

    typedef enum logic [2:0] {
        E_NONE,
        E_OK,
        E_FULL,
        E_BADPOS,
        E_NOTFOUND,
        E_EMPTY,
        E_FOUND,
        E_ELEM
    } t_emit;

    typedef struct packed {
        logic    load;
        t_ptr_op ptr_op;
        logic    rd;
        t_wr_op  wr_op;
        t_cnt_op cnt_op;
        t_emit   emit;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              pos_bad;
        logic              del_tail;
        logic              walk_end;
        logic              match;
        logic              prev_last;
        logic              out_free;
    } t_stat;

endpackage

/* rtl/core/bol_datapath.sv */
// Datapath of the ordered list unit: element memory, count, pointers and output register.
module bol_datapath import bol_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic signed [DATA_W-1:0]   i_value,
    input  logic signed [DATA_W-1:0]   i_key,
    input  logic [POS_W-1:0]           i_position,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [FPOS_W-1:0]          o_found_position,
    output logic signed [DATA_W-1:0]   o_element,
    output logic                       o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_W-1:0]   mem [CAPACITY];

    logic [FUNC_W-1:0]   r_func;
    logic [DATA_W-1:0]   r_value;
    logic [DATA_W-1:0]   r_key;
    logic [POS_W-1:0]    r_pos_eff;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [AW-1:0]       r_ptr;
    logic [AW-1:0]       n_ptr;
    logic [AW-1:0]       r_prev;
    logic [DATA_W-1:0]   r_rd_data;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [FPOS_W-1:0]   r_fpos;
    logic [DATA_W-1:0]   r_element;
    logic                r_last;

    logic                shift_up;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [CW-1:0]       last_idx;
    logic [CW-1:0]       prev_pos;

    // Insert at front walks from the top down; delete walks upward.
    assign shift_up = (r_func == FN_INS_FRONT);
    assign last_idx = r_count - 1'b1;
    assign prev_pos = CW'(r_prev) + CW'(1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_value;
        case (i_cmd.wr_op)
            W_FRONT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end
            W_REAR: begin
                wr_en   = 1'b1;
                wr_addr = r_count[AW-1:0];
            end
            W_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = shift_up ? (r_prev + 1'b1) : (r_prev - 1'b1);
                wr_data = r_rd_data;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.ptr_op)
            P_ZERO:  n_ptr = '0;
            P_TOP:   n_ptr = AW'(last_idx);
            P_POS:   n_ptr = AW'(r_pos_eff);
            P_INC:   n_ptr = r_ptr + 1'b1;
            P_DEC:   n_ptr = r_ptr - 1'b1;
            default: n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            C_INC:   n_count = r_count + 1'b1;
            C_DEC:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_ptr];
            r_prev    <= r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_value   <= i_value;
            r_key     <= i_key;
            r_pos_eff <= (i_position == '0) ? POS_W'(1) : i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit != E_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != E_NONE) begin
            r_fpos    <= (i_cmd.emit == E_FOUND) ? FPOS_W'(prev_pos) : '0;
            r_element <= (i_cmd.emit == E_ELEM) ? r_rd_data : '0;
            r_last    <= (i_cmd.emit == E_ELEM) ? (CW'(r_prev) == last_idx) : 1'b1;
            case (i_cmd.emit)
                E_FULL:     r_status <= ST_FULL;
                E_BADPOS:   r_status <= ST_BADPOS;
                E_NOTFOUND: r_status <= ST_NOTFOUND;
                E_EMPTY:    r_status <= ST_EMPTY;
                default:    r_status <= ST_OK;
            endcase
        end
    end

    always_comb begin
        o_stat.func      = r_func;
        o_stat.full      = (r_count >= CW'(CAPACITY));
        o_stat.empty     = (r_count == '0);
        o_stat.pos_bad   = (32'(r_pos_eff) > 32'(r_count));
        o_stat.del_tail  = (32'(r_pos_eff) == 32'(r_count));
        o_stat.walk_end  = shift_up ? (r_ptr == '0) : (CW'(r_ptr) == last_idx);
        o_stat.match     = (r_rd_data == r_key);
        o_stat.prev_last = (CW'(r_prev) == last_idx);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_fpos;
    assign o_element        = r_element;
    assign o_last           = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (CW'(r_ptr) < r_count))
        else $error("read of an entry outside the list");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_op == W_FRONT || i_cmd.wr_op == W_REAR) |-> !o_stat.full)
        else $error("insert write into a full list");

endmodule

/* rtl/core/bol_ctrl.sv */
// Controller state machine of the ordered list unit.
module bol_ctrl import bol_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_func,
    output logic              o_in_ready,
    input  t_stat             i_stat,
    output t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REAR,
        S_FRONT,
        S_DEL,
        S_SH0,
        S_SH,
        S_SH_LAST,
        S_FIN,
        S_SRCH,
        S_SR_CHK,
        S_DISP,
        S_DS_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;
    t_ptr_op step_op;

    assign step_op = (i_stat.func == FN_INS_FRONT) ? P_DEC : P_INC;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load   = 1'b1;
                    cmd.ptr_op = P_ZERO;
                    case (i_func)
                        FN_INS_FRONT: n_state = S_FRONT;
                        FN_INS_REAR:  n_state = S_REAR;
                        FN_DELETE:    n_state = S_DEL;
                        FN_SEARCH:    n_state = S_SRCH;
                        FN_DISPLAY:   n_state = S_DISP;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_REAR: begin
                if (i_stat.out_free) begin
                    if (i_stat.full) begin
                        cmd.emit = E_FULL;
                    end else begin
                        cmd.wr_op  = W_REAR;
                        cmd.cnt_op = C_INC;
                        cmd.emit   = E_OK;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FRONT: begin
                if (i_stat.full) begin
                    if (i_stat.out_free) begin
                        cmd.emit = E_FULL;
                        n_state  = S_IDLE;
                    end
                end else if (i_stat.empty) begin
                    if (i_stat.out_free) begin
                        cmd.wr_op  = W_FRONT;
                        cmd.cnt_op = C_INC;
                        cmd.emit   = E_OK;
                        n_state    = S_IDLE;
                    end
                end else begin
                    cmd.ptr_op = P_TOP;
                    n_state    = S_SH0;
                end
            end
            S_DEL: begin
                if (i_stat.pos_bad) begin
                    if (i_stat.out_free) begin
                        cmd.emit = E_BADPOS;
                        n_state  = S_IDLE;
                    end
                end else if (i_stat.del_tail) begin
                    n_state = S_FIN;
                end else begin
                    cmd.ptr_op = P_POS;
                    n_state    = S_SH0;
                end
            end
            // The shift reads one entry a cycle and writes the entry read
            // the cycle before into its neighbor.
            S_SH0, S_SH: begin
                cmd.rd = 1'b1;
                if (r_state == S_SH) begin
                    cmd.wr_op = W_SHIFT;
                end
                if (i_stat.walk_end) begin
                    n_state = S_SH_LAST;
                end else begin
                    cmd.ptr_op = step_op;
                    n_state    = S_SH;
                end
            end
            S_SH_LAST: begin
                cmd.wr_op = W_SHIFT;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    cmd.emit = E_OK;
                    if (i_stat.func == FN_INS_FRONT) begin
                        cmd.wr_op  = W_FRONT;
                        cmd.cnt_op = C_INC;
                    end else begin
                        cmd.cnt_op = C_DEC;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SRCH: begin
                if (i_stat.empty) begin
                    if (i_stat.out_free) begin
                        cmd.emit = E_NOTFOUND;
                        n_state  = S_IDLE;
                    end
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.ptr_op = P_INC;
                    n_state    = S_SR_CHK;
                end
            end
            S_SR_CHK: begin
                if (i_stat.match) begin
                    if (i_stat.out_free) begin
                        cmd.emit = E_FOUND;
                        n_state  = S_IDLE;
                    end
                end else if (i_stat.prev_last) begin
                    if (i_stat.out_free) begin
                        cmd.emit = E_NOTFOUND;
                        n_state  = S_IDLE;
                    end
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.ptr_op = P_INC;
                end
            end
            S_DISP: begin
                if (i_stat.empty) begin
                    if (i_stat.out_free) begin
                        cmd.emit = E_EMPTY;
                        n_state  = S_IDLE;
                    end
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.ptr_op = P_INC;
                    n_state    = S_DS_OUT;
                end
            end
            S_DS_OUT: begin
                // The next entry is read only once this word has left.
                if (i_stat.out_free) begin
                    cmd.emit = E_ELEM;
                    if (i_stat.prev_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.rd     = 1'b1;
                        cmd.ptr_op = P_INC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit != E_NONE) |-> i_stat.out_free)
        else $error("result issued while the output register is occupied");

    a_count_with_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cnt_op != C_HOLD) |-> (cmd.emit == E_OK))
        else $error("element count changed without an ok result");

    a_shift_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_op == W_SHIFT) |-> $past(cmd.rd))
        else $error("shift write without a read in the previous cycle");

endmodule

/* rtl/core/bounded_ordered_list_unit.sv */
// Top level of the ordered list unit: controller and datapath.
//
//   channel   direction  handshake                   words
//   input     in         i_in_valid / o_in_ready     i_func, i_value, i_key, i_position
//   output    out        o_out_valid / i_out_ready   o_status, o_found_position,
//                                                    o_element, o_last
//
// One word is taken at a time; the accept cycle is followed by the work below.
// Insert rear writes at the rear; insert front into a non-empty, non-full list
// and delete short of the tail shift entries one at a time through the memory;
// a full, empty or bad-position case returns its status. Search reads one entry
// per cycle to a match or the last entry; display one per cycle unless the
// output stalls. Reset clears the count, output valid and controller state; the
// memory is not cleared and needs no sweep. A stalled output holds search and
// display until the output word is taken; a shift runs to its end, then waits.
module bounded_ordered_list_unit import bol_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [FPOS_W-1:0]        o_found_position,
    output logic signed [DATA_W-1:0] o_element,
    output logic                     o_last
);

    t_cmd  cmd;
    t_stat stat;

    bol_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bol_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_key            (i_key),
        .i_position       (i_position),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_element        (o_element),
        .o_last           (o_last)
    );

endmodule
